// ===== hdl/rip_pkg.sv =====
package rip_pkg;

	// Fixed point format of all angles and speeds
	localparam int ANGLE_FRAC_BITS = 12;
	localparam int PI_Q = (3294199 + (1 << (19 - ANGLE_FRAC_BITS))) >> (20 - ANGLE_FRAC_BITS);
	localparam int TWO_PI_Q = 2 * PI_Q;

	// Width of the shared adder, signed
	localparam int ALU_W = 20;

	// Command codes
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_CANCEL = 2'd2;

	// Status codes
	localparam logic [2:0] ST_RUNNING   = 3'd0;
	localparam logic [2:0] ST_REACHED   = 3'd1;
	localparam logic [2:0] ST_CANCELLED = 3'd2;
	localparam logic [2:0] ST_POSE_ERR  = 3'd3;
	localparam logic [2:0] ST_IDLE      = 3'd4;

	// Register indexes
	localparam logic [2:0] REG_TARGET    = 3'd0;
	localparam logic [2:0] REG_ACCEL     = 3'd1;
	localparam logic [2:0] REG_MAX_SPEED = 3'd2;
	localparam logic [2:0] REG_MIN_SPEED = 3'd3;
	localparam logic [2:0] REG_TOLERANCE = 3'd4;

	// Register reset values
	localparam logic [14:0] TARGET_RST    = 15'd12868;
	localparam logic [15:0] ACCEL_RST     = 16'd13107;
	localparam logic [14:0] MAX_SPEED_RST = 15'd4096;
	localparam logic [14:0] MIN_SPEED_RST = 15'd1638;
	localparam logic [13:0] TOLERANCE_RST = 14'd410;

	typedef struct packed {
		logic [14:0] target;
		logic [15:0] accel;
		logic [14:0] max_speed;
		logic [14:0] min_speed;
		logic [13:0] tolerance;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic signed [14:0] heading;
		logic signed [14:0] yaw;
		logic               ack;
	} eng_req_t;

	typedef struct packed {
		logic        done;
		logic        reached;
		logic [14:0] speed;
	} eng_rsp_t;

endpackage

// ===== hdl/rip_engine.sv =====
module rip_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  rip_pkg::cfg_t     cfg,
	input  rip_pkg::eng_req_t req,
	output rip_pkg::eng_rsp_t rsp
);

	localparam int W = rip_pkg::ALU_W;
	localparam logic signed [W-1:0] PI_W     = W'(rip_pkg::PI_Q);
	localparam logic signed [W-1:0] TWO_PI_W = W'(rip_pkg::TWO_PI_Q);

	typedef enum logic [12:0] {
		E_IDLE   = 13'b0000000000001,
		E_BIAS   = 13'b0000000000010,
		E_WRAP   = 13'b0000000000100,
		E_CENT   = 13'b0000000001000,
		E_ABS    = 13'b0000000010000,
		E_REM    = 13'b0000000100000,
		E_REMNEG = 13'b0000001000000,
		E_TOL    = 13'b0000010000000,
		E_MUL    = 13'b0000100000000,
		E_SQRT   = 13'b0001000000000,
		E_CLMIN  = 13'b0010000000000,
		E_CLMAX  = 13'b0100000000000,
		E_DONE   = 13'b1000000000000
	} eng_state_t;

	eng_state_t         state_q;
	logic signed [W-1:0] m_q;
	logic [31:0]        prod_q;
	logic [16:0]        r_q;
	logic [15:0]        q_q;
	logic [3:0]         cnt_q;
	logic               reached_q;

	logic signed [W-1:0] alu_a;
	logic signed [W-1:0] alu_b;
	logic               alu_sub;
	logic signed [W-1:0] alu_res;
	logic               alu_neg;
	logic [30:0]        mul_w;

	// Shared adder / subtractor
	assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	assign alu_neg = alu_res[W-1];

	assign mul_w = 31'(cfg.accel) * 31'(m_q[14:0]);

	// Select operands for the current step
	always_comb begin
		alu_a   = m_q;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			E_IDLE: begin
				alu_a   = {{(W-15){req.heading[14]}}, req.heading};
				alu_b   = {{(W-15){req.yaw[14]}}, req.yaw};
				alu_sub = 1'b1;
			end
			E_BIAS: begin
				alu_b = PI_W;
			end
			E_WRAP: begin
				alu_b   = TWO_PI_W;
				alu_sub = !m_q[W-1];
			end
			E_CENT: begin
				alu_b   = PI_W;
				alu_sub = 1'b1;
			end
			E_ABS: begin
				alu_a   = '0;
				alu_b   = m_q;
				alu_sub = 1'b1;
			end
			E_REM: begin
				alu_a   = W'(cfg.target);
				alu_b   = m_q;
				alu_sub = 1'b1;
			end
			E_REMNEG: begin
				alu_b   = W'(cfg.target);
				alu_sub = 1'b1;
			end
			E_TOL: begin
				alu_b   = W'(cfg.tolerance);
				alu_sub = 1'b1;
			end
			E_SQRT: begin
				alu_a   = {1'b0, r_q, prod_q[31:30]};
				alu_b   = {2'b00, q_q, 2'b01};
				alu_sub = 1'b1;
			end
			E_CLMIN: begin
				alu_a   = W'(q_q);
				alu_b   = W'(cfg.min_speed);
				alu_sub = 1'b1;
			end
			E_CLMAX: begin
				alu_a   = W'(q_q);
				alu_b   = W'(cfg.max_speed);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = m_q;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= E_IDLE;
			reached_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				E_IDLE: begin
					if (req.start) begin
						reached_q <= 1'b0;
						state_q   <= E_BIAS;
					end
				end
				E_BIAS: state_q <= E_WRAP;
				E_WRAP: begin
					if (!m_q[W-1] && alu_neg) begin
						state_q <= E_CENT;
					end
				end
				E_CENT: state_q <= E_ABS;
				E_ABS:  state_q <= E_REM;
				E_REM: begin
					state_q <= alu_neg ? E_REMNEG : E_TOL;
				end
				E_REMNEG: state_q <= E_TOL;
				E_TOL: begin
					if (alu_neg) begin
						reached_q <= 1'b1;
						state_q   <= E_DONE;
					end else begin
						state_q <= E_MUL;
					end
				end
				E_MUL: begin
					cnt_q   <= 4'd15;
					state_q <= E_SQRT;
				end
				E_SQRT: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						state_q <= E_CLMIN;
					end
				end
				E_CLMIN: state_q <= E_CLMAX;
				E_CLMAX: state_q <= E_DONE;
				E_DONE: begin
					if (req.ack) begin
						state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	// Update the working registers
	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: begin
				if (req.start) begin
					m_q <= alu_res;
				end
			end
			E_BIAS, E_CENT, E_REMNEG: m_q <= alu_res;
			E_WRAP: begin
				// Keep adding while negative, subtract while at or above two pi
				if (m_q[W-1] || !alu_neg) begin
					m_q <= alu_res;
				end
			end
			E_ABS: begin
				if (m_q[W-1]) begin
					m_q <= alu_res;
				end
			end
			E_REM: begin
				if (!alu_neg) begin
					m_q <= alu_res;
				end
			end
			E_MUL: begin
				prod_q <= {mul_w, 1'b0};
				r_q    <= '0;
				q_q    <= '0;
			end
			E_SQRT: begin
				// One root bit per step from the next two radicand bits
				prod_q <= {prod_q[29:0], 2'b00};
				if (!alu_neg) begin
					r_q <= alu_res[16:0];
					q_q <= {q_q[14:0], 1'b1};
				end else begin
					r_q <= alu_a[16:0];
					q_q <= {q_q[14:0], 1'b0};
				end
			end
			E_CLMIN: begin
				if (alu_neg) begin
					q_q <= {1'b0, cfg.min_speed};
				end
			end
			E_CLMAX: begin
				if (!alu_neg) begin
					q_q <= {1'b0, cfg.max_speed};
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done    = (state_q == E_DONE);
	assign rsp.reached = reached_q;
	assign rsp.speed   = q_q[14:0];

endmodule

// ===== hdl/rotate_in_place_velocity_profile.sv =====
// Cancel, idle and pose error requests give their result in the cycle after acceptance.
// A sample that runs gives its result once the engine is done and the result register can
// load; short of the goal, the engine also takes 16 square root steps on the shared adder.
// One request is in work at a time; the next is taken once the result register can load.
// Reset (arst_n low) clears the block to idle, start heading to zero and the registers
// to their defaults.
module rotate_in_place_velocity_profile (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [14:0] yaw,
	input  logic               pose_valid,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [14:0]        speed_command,
	output logic [2:0]         status,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	typedef enum logic [1:0] {
		T_READY = 2'b01,
		T_BUSY  = 2'b10
	} top_state_t;

	top_state_t          state_q;
	rip_pkg::cfg_t       cfg_q;
	logic signed [14:0]  heading_q;
	logic                active_q;
	logic                out_valid_q;
	logic [14:0]         speed_q;
	logic [2:0]          status_q;

	rip_pkg::eng_req_t   req;
	rip_pkg::eng_rsp_t   rsp;

	logic accept;
	logic out_free;
	logic cancel;
	logic is_start;
	logic launch;
	logic out_load;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == T_READY) && out_free;
	assign accept   = in_valid && in_ready;
	assign cancel   = (cmd != rip_pkg::CMD_START) && (cmd != rip_pkg::CMD_SAMPLE);
	assign is_start = (cmd == rip_pkg::CMD_START);
	assign launch   = accept && !cancel && pose_valid && (is_start || active_q);

	// Load the result register on a direct result or when the engine hands one over
	assign out_load = (accept && !launch) || req.ack;

	assign req.start   = launch;
	assign req.heading = is_start ? yaw : heading_q;
	assign req.yaw     = yaw;
	assign req.ack     = (state_q == T_BUSY) && rsp.done && out_free;

	rip_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.rsp    (rsp)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target    <= rip_pkg::TARGET_RST;
			cfg_q.accel     <= rip_pkg::ACCEL_RST;
			cfg_q.max_speed <= rip_pkg::MAX_SPEED_RST;
			cfg_q.min_speed <= rip_pkg::MIN_SPEED_RST;
			cfg_q.tolerance <= rip_pkg::TOLERANCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rip_pkg::REG_TARGET:    cfg_q.target    <= cfg_data[14:0];
				rip_pkg::REG_ACCEL:     cfg_q.accel     <= cfg_data;
				rip_pkg::REG_MAX_SPEED: cfg_q.max_speed <= cfg_data[14:0];
				rip_pkg::REG_MIN_SPEED: cfg_q.min_speed <= cfg_data[14:0];
				rip_pkg::REG_TOLERANCE: cfg_q.tolerance <= cfg_data[13:0];
				default: begin
				end
			endcase
		end
	end

	// Decode requests, track rotation state and load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_READY;
			heading_q   <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			speed_q     <= '0;
			status_q    <= rip_pkg::ST_IDLE;
		end else begin
			case (state_q)
				T_READY: begin
					if (accept) begin
						if (cancel) begin
							active_q    <= 1'b0;
							speed_q     <= '0;
							status_q    <= rip_pkg::ST_CANCELLED;
						end else if (!pose_valid && (is_start || active_q)) begin
							active_q    <= 1'b0;
							speed_q     <= '0;
							status_q    <= rip_pkg::ST_POSE_ERR;
						end else if (!is_start && !active_q) begin
							speed_q     <= '0;
							status_q    <= rip_pkg::ST_IDLE;
						end else begin
							if (is_start) begin
								heading_q <= yaw;
							end
							active_q <= 1'b1;
							state_q  <= T_BUSY;
						end
					end
				end
				T_BUSY: begin
					if (req.ack) begin
						if (rsp.reached) begin
							active_q <= 1'b0;
							speed_q  <= '0;
							status_q <= rip_pkg::ST_REACHED;
						end else begin
							speed_q  <= rsp.speed;
							status_q <= rip_pkg::ST_RUNNING;
						end
						state_q     <= T_READY;
					end
				end
				default: state_q <= T_READY;
			endcase
			// Hold the result until taken, drop it once the receiver accepts
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign speed_command = speed_q;
	assign status        = status_q;

	// A nonzero speed only goes out with a running status
	a_speed_running: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != rip_pkg::ST_RUNNING)) |-> (speed_command == '0))
		else $error("nonzero speed with non-running status");

	// A running result leaves the block active
	a_running_active: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == rip_pkg::ST_RUNNING)) |-> active_q)
		else $error("running result while inactive");

	// The engine finishes only while a request is in work
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == T_BUSY))
		else $error("engine done outside busy state");

	// A launched request takes the block out of ready
	a_launch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		launch |=> (!in_ready && (state_q == T_BUSY)))
		else $error("ready after launch");

endmodule
